/* rtl/rgbpc_pkg.sv */
// rgbpc_pkg: shared types, register codes and reset values of the rgb period classifier
// no dependencies; used by rgbpc_out_if, rgbpc_front, rgbpc_back and the top level
package rgbpc_pkg;

  localparam int FREQ_W   = 16;
  localparam int CNT_W    = 4;
  localparam int SETTLE_W = 8;
  localparam int LANE_W   = 16;
  localparam int BOX_W    = 48;
  localparam int CH_W     = 2;
  localparam int CLASS_W  = 2;
  localparam int PDATA_W  = 64;
  localparam int PADDR_W  = 6;
  localparam int BOX_SLOTS = 3;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd3;

  localparam logic [2:0] REG_NUMERATOR = 3'd0;
  localparam logic [2:0] REG_SETTLE    = 3'd1;
  localparam logic [2:0] REG_BOX_BASE  = 3'd2;

  localparam logic [FREQ_W-1:0]   NUMERATOR_RESET = 16'd12000;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET    = 8'd1;

  typedef struct packed {
    logic [BOX_W-1:0] low;
    logic [BOX_W-1:0] high;
  } box_t;

  localparam box_t BOX_RESET [BOX_SLOTS] = '{
    '{low: 48'h001A_0012_001A, high: 48'h001C_0015_001C},
    '{low: 48'h004E_0046_004E, high: 48'h0051_0049_0064},
    '{low: 48'h0032_001E_003A, high: 48'h0037_0030_003E}
  };

  typedef struct packed {
    logic [CH_W-1:0]    measured_channel;
    logic [FREQ_W-1:0]  frequency;
    logic [CH_W-1:0]    next_channel;
    logic [FREQ_W-1:0]  red_value;
    logic [FREQ_W-1:0]  green_value;
    logic               class_valid;
    logic [CLASS_W-1:0] color_class;
  } result_t;

  function automatic logic [CH_W-1:0] next_channel(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] nx;
    if (ch == CH_BLUE || ch == CLASS_UNKNOWN) begin
      nx = CH_RED;
    end else begin
      nx = ch + 2'd1;
    end
    return nx;
  endfunction

endpackage

/* rtl/rgbpc_in_if.sv */
// rgbpc_in_if: valid/ready channel carrying sensor edge stamps
// no dependencies
interface rgbpc_in_if #(
  parameter int TIMER_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [TIMER_BITS-1:0] edge_stamp;

  modport source(output valid, output edge_stamp, input ready);
  modport sink(input valid, input edge_stamp, output ready);
endinterface

/* rtl/rgbpc_out_if.sv */
// rgbpc_out_if: valid/ready channel carrying measurement and class results
// depends on rgbpc_pkg for field widths
interface rgbpc_out_if;
  logic                                valid;
  logic                                ready;
  logic [rgbpc_pkg::CH_W-1:0]          measured_channel;
  logic [rgbpc_pkg::FREQ_W-1:0]        frequency;
  logic [rgbpc_pkg::CH_W-1:0]          next_channel;
  logic [rgbpc_pkg::FREQ_W-1:0]        red_value;
  logic [rgbpc_pkg::FREQ_W-1:0]        green_value;
  logic                                class_valid;
  logic [rgbpc_pkg::CLASS_W-1:0]       color_class;

  modport source(output valid, output measured_channel, output frequency,
                 output next_channel, output red_value, output green_value,
                 output class_valid, output color_class, input ready);
  modport sink(input valid, input measured_channel, input frequency,
               input next_channel, input red_value, input green_value,
               input class_valid, input color_class, output ready);
endinterface

/* rtl/rgbpc_front.sv */
// rgbpc_front: edge sequencer, settle discard, period stamping and channel rotation
// depends on rgbpc_pkg and rgbpc_in_if; pushes channel and period jobs into the queue
module rgbpc_front #(
  parameter int TIMER_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rgbpc_in_if.sink                             in_i,
  input  logic [rgbpc_pkg::SETTLE_W-1:0]       settle_edges_i,
  input  logic                                 job_full_i,
  output logic                                 job_push_o,
  output logic [rgbpc_pkg::CH_W+TIMER_BITS-1:0] job_data_o
);

  logic [rgbpc_pkg::CH_W-1:0]     chan_q;
  logic [rgbpc_pkg::SETTLE_W-1:0] disc_q;
  logic                           have_q;
  logic [TIMER_BITS-1:0]          first_q;
  logic                           accept;
  logic [TIMER_BITS-1:0]          period;

  assign in_i.ready = !job_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign period     = in_i.edge_stamp - first_q;
  assign job_push_o = accept && (disc_q == '0) && have_q;
  assign job_data_o = {chan_q, period};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= rgbpc_pkg::CH_RED;
      disc_q <= rgbpc_pkg::SETTLE_RESET;
      have_q <= 1'b0;
    end else if (accept) begin
      if (disc_q != '0) begin
        disc_q <= disc_q - 8'd1;
      end else if (!have_q) begin
        have_q <= 1'b1;
      end else begin
        chan_q <= rgbpc_pkg::next_channel(chan_q);
        have_q <= 1'b0;
        disc_q <= settle_edges_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (disc_q == '0) && !have_q) begin
      first_q <= in_i.edge_stamp;
    end
  end

endmodule

/* rtl/rgbpc_queue.sv */
// rgbpc_queue: two-entry fifo between the edge front and the divider back
// no dependencies
module rgbpc_queue #(
  parameter int WIDTH = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wptr_q;
  logic             rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/rgbpc_back.sv */
// rgbpc_back: serial restoring divider, rgb value store, box classifier, result register
// depends on rgbpc_pkg and rgbpc_out_if; pops jobs from rgbpc_queue
module rgbpc_back #(
  parameter int TIMER_BITS  = 16,
  parameter int NUM_CLASSES = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  job_valid_i,
  input  logic [rgbpc_pkg::CH_W+TIMER_BITS-1:0] job_data_i,
  output logic                                  job_pop_o,
  input  logic [rgbpc_pkg::FREQ_W-1:0]          numerator_i,
  input  rgbpc_pkg::box_t                       boxes_i [NUM_CLASSES],
  rgbpc_out_if.source                           out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int FW = rgbpc_pkg::FREQ_W;
  localparam int LW = rgbpc_pkg::LANE_W;

  logic [1:0]                    state_q;
  logic [rgbpc_pkg::CNT_W-1:0]   cnt_q;
  logic [rgbpc_pkg::CH_W-1:0]    ch_q;
  logic [TIMER_BITS-1:0]         div_q;
  logic [TIMER_BITS-1:0]         rem_q;
  logic [FW-1:0]                 quo_q;
  logic [FW-1:0]                 red_q;
  logic [FW-1:0]                 green_q;
  logic                          out_vq;
  rgbpc_pkg::result_t            res_q;

  logic [rgbpc_pkg::CH_W-1:0]    job_ch;
  logic [TIMER_BITS-1:0]         job_period;
  logic [TIMER_BITS:0]           rem_sh;
  logic                          ge;
  logic [TIMER_BITS-1:0]         rem_nx;
  logic                          emit;
  logic [rgbpc_pkg::CLASS_W-1:0] cls;

  assign job_ch     = job_data_i[rgbpc_pkg::CH_W+TIMER_BITS-1:TIMER_BITS];
  assign job_period = job_data_i[TIMER_BITS-1:0];
  assign job_pop_o  = (state_q == S_IDLE) && job_valid_i;
  assign emit       = (state_q == S_DONE) && (!out_vq || out_o.ready);

  assign rem_sh = {rem_q, quo_q[FW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rem_nx = ge ? TIMER_BITS'(rem_sh - {1'b0, div_q}) : rem_sh[TIMER_BITS-1:0];

  // lowest matching box wins
  always_comb begin
    cls = rgbpc_pkg::CLASS_UNKNOWN;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (red_q   >= boxes_i[k].low[3*LW-1:2*LW] && red_q   <= boxes_i[k].high[3*LW-1:2*LW] &&
          green_q >= boxes_i[k].low[2*LW-1:LW]   && green_q <= boxes_i[k].high[2*LW-1:LW] &&
          quo_q   >= boxes_i[k].low[LW-1:0]      && quo_q   <= boxes_i[k].high[LW-1:0]) begin
        cls = rgbpc_pkg::CLASS_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_vq  <= 1'b0;
      red_q   <= '0;
      green_q <= '0;
    end else begin
      out_vq <= (out_vq && !out_o.ready) || emit;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            state_q <= (job_period == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            state_q <= S_IDLE;
            if (ch_q == rgbpc_pkg::CH_RED) begin
              red_q <= quo_q;
            end
            if (ch_q == rgbpc_pkg::CH_GREEN) begin
              green_q <= quo_q;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      ch_q  <= job_ch;
      div_q <= job_period;
      rem_q <= '0;
      quo_q <= numerator_i;
      cnt_q <= rgbpc_pkg::CNT_W'(FW - 1);
    end else if (state_q == S_DIV) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[FW-2:0], ge};
      cnt_q <= cnt_q - 4'd1;
    end
    if (emit) begin
      res_q.measured_channel <= ch_q;
      res_q.frequency        <= quo_q;
      res_q.next_channel     <= rgbpc_pkg::next_channel(ch_q);
      res_q.red_value        <= (ch_q == rgbpc_pkg::CH_RED) ? quo_q : red_q;
      res_q.green_value      <= (ch_q == rgbpc_pkg::CH_GREEN) ? quo_q : green_q;
      res_q.class_valid      <= (ch_q == rgbpc_pkg::CH_BLUE);
      res_q.color_class      <= (ch_q == rgbpc_pkg::CH_BLUE) ? cls : rgbpc_pkg::CLASS_NONE;
    end
  end

  assign out_o.valid            = out_vq;
  assign out_o.measured_channel = res_q.measured_channel;
  assign out_o.frequency        = res_q.frequency;
  assign out_o.next_channel     = res_q.next_channel;
  assign out_o.red_value        = res_q.red_value;
  assign out_o.green_value      = res_q.green_value;
  assign out_o.class_valid      = res_q.class_valid;
  assign out_o.color_class      = res_q.color_class;

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> state_q == S_DONE)
    else $error("divider did not finish after last step");

  a_div_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_pop_o && job_period != '0) |=> state_q == S_DIV)
    else $error("nonzero period did not start the divider");

  a_class_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq |-> (res_q.class_valid == (res_q.measured_channel == rgbpc_pkg::CH_BLUE)))
    else $error("class_valid does not match blue measurement");

  a_class_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && !res_q.class_valid) |-> res_q.color_class == rgbpc_pkg::CLASS_NONE)
    else $error("color_class set without class_valid");

endmodule

/* rtl/rgb_period_color_classifier.sv */
// rgb_period_color_classifier: top level with apb register file, front, queue and back
// depends on rgbpc_pkg, rgbpc_in_if, rgbpc_out_if, rgbpc_front, rgbpc_queue, rgbpc_back
//
// in_i carries one timer stamp per rising edge of the sensor output; out_o carries one
// result per completed channel measurement. Per channel, settle_edges edges are dropped,
// the next edge is stamped and the one after ends the period. The front handles each edge
// as it is accepted and keeps accepting while the two-entry job queue has room.
// The back pops a job, runs a one-bit-per-cycle restoring divider (a zero period
// skips it), then loads the result register and raises out_o.valid; it pops no new
// job until that result is loaded.
// Blue results also carry the first matching color box, or unknown.
// When out_o stalls the result register holds, the back finishes its next division and
// waits, and once the queue fills in_i.ready drops.
// Reset clears channel to red, the discard count to the settle reset, the stored red and
// green values to zero, and loads the register reset values. Registers sit at byte
// address 8*index, 64-bit data, pready always high; write only while the block is idle.
module rgb_period_color_classifier #(
  parameter int TIMER_BITS  = 16,
  parameter int NUM_CLASSES = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rgbpc_in_if.sink                        in_i,
  rgbpc_out_if.source                     out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [rgbpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [rgbpc_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);

  localparam int JOB_W = rgbpc_pkg::CH_W + TIMER_BITS;

  logic [rgbpc_pkg::FREQ_W-1:0]   numerator_q;
  logic [rgbpc_pkg::SETTLE_W-1:0] settle_q;
  rgbpc_pkg::box_t                box_q [NUM_CLASSES];
  logic [2:0]                     reg_idx;
  logic                           wr_en;

  logic             job_push;
  logic [JOB_W-1:0] job_wdata;
  logic             job_full;
  logic             job_pop;
  logic             job_valid;
  logic [JOB_W-1:0] job_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rgbpc_pkg::PADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_q <= rgbpc_pkg::NUMERATOR_RESET;
      settle_q    <= rgbpc_pkg::SETTLE_RESET;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        box_q[k] <= rgbpc_pkg::BOX_RESET[k];
      end
    end else if (wr_en) begin
      if (reg_idx == rgbpc_pkg::REG_NUMERATOR) begin
        numerator_q <= pwdata[rgbpc_pkg::FREQ_W-1:0];
      end
      if (reg_idx == rgbpc_pkg::REG_SETTLE) begin
        settle_q <= pwdata[rgbpc_pkg::SETTLE_W-1:0];
      end
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (reg_idx == rgbpc_pkg::REG_BOX_BASE + 3'(2 * k)) begin
          box_q[k].low <= pwdata[rgbpc_pkg::BOX_W-1:0];
        end
        if (reg_idx == rgbpc_pkg::REG_BOX_BASE + 3'(2 * k + 1)) begin
          box_q[k].high <= pwdata[rgbpc_pkg::BOX_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rgbpc_pkg::REG_NUMERATOR) begin
      prdata = rgbpc_pkg::PDATA_W'(numerator_q);
    end
    if (reg_idx == rgbpc_pkg::REG_SETTLE) begin
      prdata = rgbpc_pkg::PDATA_W'(settle_q);
    end
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (reg_idx == rgbpc_pkg::REG_BOX_BASE + 3'(2 * k)) begin
        prdata = rgbpc_pkg::PDATA_W'(box_q[k].low);
      end
      if (reg_idx == rgbpc_pkg::REG_BOX_BASE + 3'(2 * k + 1)) begin
        prdata = rgbpc_pkg::PDATA_W'(box_q[k].high);
      end
    end
  end

  rgbpc_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .settle_edges_i(settle_q),
    .job_full_i    (job_full),
    .job_push_o    (job_push),
    .job_data_o    (job_wdata)
  );

  rgbpc_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_wdata),
    .full_o (job_full),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .data_o (job_rdata)
  );

  rgbpc_back #(
    .TIMER_BITS (TIMER_BITS),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_data_i (job_rdata),
    .job_pop_o  (job_pop),
    .numerator_i(numerator_q),
    .boxes_i    (box_q),
    .out_o      (out_o)
  );

endmodule
